// ===== rtl/stable_sorted_priority_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue cells and top.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VALUE_W      = 32;
  localparam int PRIO_W       = 16;
  localparam int COUNT_W      = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast to every cell for one request
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [VALUE_W-1:0] val;
    logic signed [PRIO_W-1:0]  pri;
  } spq_ctrl_t;

endpackage

// ===== rtl/stable_sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// Bounded priority queue kept sorted in a chain of slots, smallest priority
// first, equal priorities in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_opcode, in_item_value and in_priority_req with
//   start high; the request is taken at a clock edge where busy is low.
//   busy never rises, so one request is taken every cycle.
//   Insert places the entry behind all held entries of lower or equal
//   priority; remove pops the front entry.
//   Result channel: exactly one result per request, shown for one cycle with
//   out_strobe high, in the cycle after the request was taken (throughput 1
//   request per cycle). Every slot compares against the new priority and
//   shifts to its neighbor in the same cycle, so the chain length does not
//   affect the rate.
//   out_status reports a refused insert (queue full) or a remove on an empty
//   queue; the queue is left unchanged then. out_entry_count gives the low
//   five bits of the count after the request.
//   The receiver cannot stall; it must take each strobed result.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "stable_sorted_priority_queue_core_defines.svh"

module stable_sorted_priority_queue_core import spq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_opcode,
  input  logic signed [VALUE_W-1:0] in_item_value,
  input  logic signed [PRIO_W-1:0]  in_priority_req,
  output logic                      out_strobe,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [COUNT_W-1:0]        out_entry_count,
  output logic                      out_queue_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             strobe_r;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic             valid_r, valid_nxt;
  status_t          status_r, status_nxt;

  logic             accept;
  logic             full, empty;
  spq_ctrl_t        ctrl;

  logic signed [VALUE_W-1:0] cell_val [CAPACITY];
  logic signed [PRIO_W-1:0]  cell_pri [CAPACITY];
  logic                      cell_le  [CAPACITY];

  logic [CNT_W+COUNT_W-1:0]  count_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  // request decode and result
  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    ctrl.val   = in_item_value;
    ctrl.pri   = in_priority_req;
    count_nxt  = count_r;
    value_nxt  = '0;
    valid_nxt  = 1'b0;
    status_nxt = ST_OK;
    if (accept) begin
      unique case (op_t'(in_opcode))
        OP_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctrl.rem  = 1'b1;
            value_nxt = cell_val[0];
            valid_nxt = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // count and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    valid_r  <= valid_nxt;
    status_r <= status_nxt;
  end

  // chain of slots, slot 0 is the front
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      occ;
    logic                      l_le;
    logic signed [VALUE_W-1:0] l_val, r_val;
    logic signed [PRIO_W-1:0]  l_pri, r_pri;

    assign occ = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign l_le  = 1'b1;
      assign l_val = '0;
      assign l_pri = '0;
    end else begin : g_mid
      assign l_le  = cell_le[i-1];
      assign l_val = cell_val[i-1];
      assign l_pri = cell_pri[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_val = '0;
      assign r_pri = '0;
    end else begin : g_inner
      assign r_val = cell_val[i+1];
      assign r_pri = cell_pri[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ),
      .left_le   (l_le),
      .left_val  (l_val),
      .left_pri  (l_pri),
      .right_val (r_val),
      .right_pri (r_pri),
      .val       (cell_val[i]),
      .pri       (cell_pri[i]),
      .le        (cell_le[i])
    );
  end

  // outputs
  assign count_ext       = (CNT_W + COUNT_W)'(count_r);
  assign out_strobe      = strobe_r;
  assign out_value       = value_r;
  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_entry_count = count_ext[COUNT_W-1:0];
  assign out_queue_empty = empty;

  // checks
  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SPQ_ASSERT_NEXT(a_result_follows, accept, out_strobe)
  `SPQ_ASSERT_NOW(a_valid_ok, out_strobe && out_valid, out_status == ST_OK)
  `SPQ_ASSERT_NEXT(a_full_holds, accept && !in_opcode && full, count_r == $past(count_r))
  `SPQ_ASSERT_NOW(a_front_sorted, count_r >= CNT_W'(2), cell_pri[0] <= cell_pri[1])

endmodule

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert
// behind the new entry, shifts left on remove.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  logic                      clk,
  input  spq_ctrl_t                 ctrl,
  input  logic                      occupied,
  input  logic                      left_le,
  input  logic signed [VALUE_W-1:0] left_val,
  input  logic signed [PRIO_W-1:0]  left_pri,
  input  logic signed [VALUE_W-1:0] right_val,
  input  logic signed [PRIO_W-1:0]  right_pri,
  output logic signed [VALUE_W-1:0] val,
  output logic signed [PRIO_W-1:0]  pri,
  output logic                      le
);

  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic signed [PRIO_W-1:0]  pri_r, pri_nxt;

  // held entry stays ahead of the new one (equal priority keeps arrival order)
  assign le = occupied && (pri_r <= ctrl.pri);

  // slot update
  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    if (ctrl.ins) begin
      if (le) begin
        val_nxt = val_r;
        pri_nxt = pri_r;
      end else if (left_le) begin
        val_nxt = ctrl.val;
        pri_nxt = ctrl.pri;
      end else begin
        val_nxt = left_val;
        pri_nxt = left_pri;
      end
    end else if (ctrl.rem) begin
      val_nxt = right_val;
      pri_nxt = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

  assign val = val_r;
  assign pri = pri_r;

endmodule

// ===== tb/tb_stable_sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Drives insert and remove requests through the start/busy handshake and
// checks every strobed result against an in-bench queue model or a pinned row:
// pop order by priority with arrival order kept on ties, full and empty
// refusals, count, empty flag. A short directed table comes first, then random
// traffic in fill, drain and mixed bursts under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int DEPTH        = CAPACITY_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_PER_PHASE = 282;

  // one result as seen on the result ports
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      valid;
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic                      empty;
  } pq_outcome_t;

  // directed row: reps > 1 repeats the request with value + k, prio - k%3
  typedef struct {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    int                        reps;
    bit                        pinned;
    pq_outcome_t               pinned_res;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_opcode;
  logic signed [VALUE_W-1:0] in_item_value;
  logic signed [PRIO_W-1:0]  in_priority_req;
  logic                      out_strobe;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic [COUNT_W-1:0]        out_entry_count;
  logic                      out_queue_empty;

  // typed-in result travels with its request
  logic                      pin_en;
  pq_outcome_t               pin_res;

  // queue model state
  logic signed [VALUE_W-1:0] slot_value [DEPTH];
  logic signed [PRIO_W-1:0]  slot_prio  [DEPTH];
  int                        held;

  pq_outcome_t               pending_results [$];
  int                        mismatches;
  int                        idle_pct;
  int                        stall_cycles;
  int                        n_inserted, n_refused, n_popped, n_underflow;

  dir_row_t directed_rows [0:9] = '{
    '{OP_REMOVE, 32'sh0, 16'sh0, 1, 1'b1, '{32'sh0, 1'b0, ST_EMPTY, 5'd0, 1'b1}},
    '{OP_INSERT, 32'sh7FFFFFFF, 16'sh7FFF, 1, 1'b1,
      '{32'sh0, 1'b0, ST_OK, 5'd1, 1'b0}},
    '{OP_INSERT, 32'sh80000000, 16'sh8000, 1, 1'b1,
      '{32'sh0, 1'b0, ST_OK, 5'd2, 1'b0}},
    '{OP_INSERT, 32'sh0, 16'sh0, 1, 1'b0, '{32'sh0, 1'b0, ST_OK, 5'd0, 1'b0}},
    '{OP_REMOVE, 32'shFFFFFFFF, 16'shFFFF, 1, 1'b1,
      '{32'sh80000000, 1'b1, ST_OK, 5'd2, 1'b0}},
    '{OP_REMOVE, 32'sh0, 16'sh0, 1, 1'b0, '{32'sh0, 1'b0, ST_OK, 5'd0, 1'b0}},
    '{OP_REMOVE, 32'sh0, 16'sh0, 1, 1'b1,
      '{32'sh7FFFFFFF, 1'b1, ST_OK, 5'd0, 1'b1}},
    '{OP_REMOVE, 32'sh0, 16'sh0, 1, 1'b1, '{32'sh0, 1'b0, ST_EMPTY, 5'd0, 1'b1}},
    // fill to capacity; interleaved equal priorities test arrival order
    '{OP_INSERT, 32'sd1000, 16'sd7, DEPTH, 1'b0,
      '{32'sh0, 1'b0, ST_OK, 5'd0, 1'b0}},
    '{OP_INSERT, 32'sh5A5A5A5A, 16'sh0, 1, 1'b1,
      '{32'sh0, 1'b0, ST_FULL, 5'd16, 1'b0}}
  };

  stable_sorted_priority_queue_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_item_value   (in_item_value),
    .in_priority_req (in_priority_req),
    .out_strobe      (out_strobe),
    .out_value       (out_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_queue_empty (out_queue_empty)
  );

  always #5 clk = ~clk;

  // queue model: apply one request, return the result it produces
  function automatic pq_outcome_t apply_request(op_t op, logic signed [VALUE_W-1:0] v,
                                                logic signed [PRIO_W-1:0] p);
    pq_outcome_t res;
    int          pos;
    res = '{32'sh0, 1'b0, ST_OK, 5'd0, 1'b0};
    if (op == OP_INSERT) begin
      if (held >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // go behind every entry of lower or equal priority
        pos = 0;
        while (pos < held && slot_prio[pos] <= p) pos++;
        for (int i = held; i > pos; i--) begin
          slot_value[i] = slot_value[i-1];
          slot_prio[i]  = slot_prio[i-1];
        end
        slot_value[pos] = v;
        slot_prio[pos]  = p;
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.value = slot_value[0];
        res.valid = 1'b1;
        for (int i = 1; i < held; i++) begin
          slot_value[i-1] = slot_value[i];
          slot_prio[i-1]  = slot_prio[i];
        end
        held--;
      end
    end
    res.count = COUNT_W'(held);
    res.empty = (held == 0);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // one request: optional idle gap, then hold start until taken
  task automatic send_request(input op_t op, input logic signed [VALUE_W-1:0] v,
                              input logic signed [PRIO_W-1:0] p, input bit pinned,
                              input pq_outcome_t pres);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_item_value   <= v;
    in_priority_req <= p;
    pin_en          <= pinned;
    pin_res         <= pres;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // result check and request capture, both on pre-edge values
  always @(posedge clk) begin
    pq_outcome_t want;
    pq_outcome_t predicted;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with no request pending", out_value, 32'h0);
        end else begin
          want = pending_results.pop_front();
          if (out_value !== want.value) flag_mismatch("value", out_value, want.value);
          if (out_valid !== want.valid) flag_mismatch("valid", out_valid, want.valid);
          if (out_status !== want.status) flag_mismatch("status", out_status, want.status);
          if (out_entry_count !== want.count)
            flag_mismatch("entry count", out_entry_count, want.count);
          if (out_queue_empty !== want.empty)
            flag_mismatch("empty flag", out_queue_empty, want.empty);
        end
      end
      if (start && !busy) begin
        predicted = apply_request(op_t'(in_opcode), in_item_value, in_priority_req);
        pending_results.push_back(pin_en ? pin_res : predicted);
        if (predicted.status == ST_FULL) n_refused++;
        else if (predicted.status == ST_EMPTY) n_underflow++;
        else if (predicted.valid) n_popped++;
        else n_inserted++;
      end
    end
  end

  // watchdog: cycles with neither a request taken nor a result shown
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int                        ins_pct;
    int                        burst_left;
    op_t                       op;
    logic signed [VALUE_W-1:0] v;
    logic signed [PRIO_W-1:0]  p;
    clk             = 1'b0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_opcode       <= 1'b0;
    in_item_value   <= '0;
    in_priority_req <= '0;
    pin_en          <= 1'b0;
    pin_res         <= '{32'sh0, 1'b0, ST_OK, 5'd0, 1'b0};
    held            = 0;
    mismatches      = 0;
    idle_pct        = 0;
    n_inserted      = 0;
    n_refused       = 0;
    n_popped        = 0;
    n_underflow     = 0;
    burst_left      = 0;
    ins_pct         = 50;
    for (int i = 0; i < DEPTH; i++) begin
      slot_value[i] = '0;
      slot_prio[i]  = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_request(directed_rows[r].op, directed_rows[r].value + k,
                     directed_rows[r].prio - PRIO_W'(k % 3),
                     directed_rows[r].pinned, directed_rows[r].pinned_res);
      end
    end

    // random traffic: idle rates none, 45%, 9%, none
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 45 : (phase == 2) ? 9 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // fill, drain or mixed bursts so both full and empty get reached
        if (burst_left == 0) begin
          burst_left = $urandom_range(40, 8);
          case ($urandom_range(2))
            0:       ins_pct = 85;
            1:       ins_pct = 15;
            default: ins_pct = 50;
          endcase
        end
        burst_left--;
        op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        case ($urandom_range(15))
          0:       v = 32'sh7FFFFFFF;
          1:       v = 32'sh80000000;
          default: v = VALUE_W'($urandom());
        endcase
        // mostly a narrow priority band to force ties
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: p = PRIO_W'($signed($urandom_range(8)) - 4);
          6:                p = ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
          default:          p = PRIO_W'($urandom());
        endcase
        send_request(op, v, p, 1'b0, pin_res);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("results never shown", pending_results.size(), 32'h0);

    $display("covered %0d inserts, %0d refused when full, %0d pops, %0d pops on empty",
             n_inserted, n_refused, n_popped, n_underflow);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_sorted_priority_queue_core.sv
tb/tb_stable_sorted_priority_queue_core.sv
